@@ rtl/s3tc_pkg.sv @@
// Shared types, register codes and palette arithmetic for the S3TC block decoder.
// Used by s3tc_block_decoder; depends on nothing else.
package s3tc_pkg;

  localparam int MAX_IMAGE_SIZE = 4096;
  localparam int SIZE_W         = 13;
  localparam int COL_W          = 10;
  localparam int BCNT_W         = 11;
  localparam int COORD_W        = 12;

  localparam logic [1:0] FMT_DXT1 = 2'd0;
  localparam logic [1:0] FMT_DXT3 = 2'd1;

  localparam logic [1:0] CFG_FORMAT = 2'd0;
  localparam logic [1:0] CFG_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_HEIGHT = 2'd2;

  typedef logic [3:0][7:0] chan4_t;
  typedef logic [7:0][7:0] atab_t;

  // Floor of v * 255 / 31, written as 8v plus floor(7v / 31).
  function automatic logic [7:0] exp5(input logic [4:0] v);
    logic [2:0] t;
    t = 3'(v >= 5'd5) + 3'(v >= 5'd9) + 3'(v >= 5'd14) + 3'(v >= 5'd18)
      + 3'(v >= 5'd23) + 3'(v >= 5'd27) + 3'(v >= 5'd31);
    return {v, 3'b000} + {5'd0, t};
  endfunction

  // Floor of v * 255 / 63, written as 4v plus floor(v / 21).
  function automatic logic [7:0] exp6(input logic [5:0] v);
    logic [1:0] t;
    t = 2'(v >= 6'd21) + 2'(v >= 6'd42) + 2'(v >= 6'd63);
    return {v, 2'b00} + {6'd0, t};
  endfunction

  // Floor division by 3 of values up to 765.
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [19:0] p;
    p = 20'(x) * 20'd683;
    return p[18:11];
  endfunction

  // Floor division by 7 of values up to 1785.
  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [22:0] p;
    p = 23'(x) * 23'd2341;
    return p[21:14];
  endfunction

  // Floor division by 5 of values up to 1275.
  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [22:0] p;
    p = 23'(x) * 23'd3277;
    return p[21:14];
  endfunction

  function automatic atab_t alpha_table(input logic [7:0] a0, input logic [7:0] a1);
    atab_t      t;
    logic [10:0] s;
    t[0] = a0;
    t[1] = a1;
    if (a0 > a1) begin
      for (int k = 1; k <= 6; k++) begin
        s = 11'(7 - k) * 11'(a0) + 11'(k) * 11'(a1);
        t[k + 1] = div7(s);
      end
    end else begin
      for (int k = 1; k <= 4; k++) begin
        s = 11'(5 - k) * 11'(a0) + 11'(k) * 11'(a1);
        t[k + 1] = div5(s);
      end
      t[6] = 8'd0;
      t[7] = 8'd255;
    end
    return t;
  endfunction

endpackage

@@ rtl/s3tc_block_decoder.sv @@
// S3TC (DXT1 / DXT3 / DXT5) block decoder: one compressed 4x4 block in, its RGBA8 pixels out.
// Depends on s3tc_pkg for register codes, types and palette arithmetic.

// A block is taken into an input register, its palette is built into the emit register,
// and its visible pixels then leave one per cycle, unless out_tready holds them, in raster
// order through an output register. A block yields all 16 pixels inside the image, fewer
// on the right and bottom edges, and none for a block outside the image, though such a
// block still passes through the emit register and leaves the output idle meanwhile.
// The single pixel output port sets this rate; blocks inside the image follow each
// other without gaps, and a block passes the input, emit and output registers in turn
// before its first pixel appears. Configuration writes are taken at any time but must only be made
// while the decoder is idle.
module s3tc_block_decoder (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // alpha_word[63:0], color_word[127:64]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [55:0]  out_tdata,  // pixel_x, pixel_y, red, green, blue, alpha
  output logic         out_tlast,  // block_end
  output logic         out_tuser,  // image_end
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [12:0]  cfg_data
);

  logic [1:0]                      fmt_r;
  logic [s3tc_pkg::SIZE_W-1:0]     width_r;
  logic [s3tc_pkg::SIZE_W-1:0]     height_r;
  logic [s3tc_pkg::COL_W-1:0]      col_r;
  logic [s3tc_pkg::COL_W-1:0]      row_r;

  logic                            inq_valid_r;
  logic [63:0]                     inq_aw_r;
  logic [63:0]                     inq_cw_r;

  logic                            em_valid_r;
  logic [1:0]                      em_fmt_r;
  logic                            em_trans_r;
  s3tc_pkg::chan4_t                em_red_r;
  s3tc_pkg::chan4_t                em_grn_r;
  s3tc_pkg::chan4_t                em_blu_r;
  s3tc_pkg::atab_t                 em_atab_r;
  logic [31:0]                     em_idx_r;
  logic [63:0]                     em_aw_r;
  logic [s3tc_pkg::COL_W-1:0]      em_col_r;
  logic [s3tc_pkg::COL_W-1:0]      em_row_r;
  logic [1:0]                      em_cx_last_r;
  logic [1:0]                      em_cy_last_r;
  logic                            em_last_blk_r;
  logic [1:0]                      cx_r;
  logic [1:0]                      cy_r;

  logic                            out_valid_r;
  logic [55:0]                     out_data_r;
  logic                            out_last_r;
  logic                            out_user_r;

  logic [s3tc_pkg::SIZE_W-1:0]     w_clamp;
  logic [s3tc_pkg::SIZE_W-1:0]     h_clamp;
  logic [s3tc_pkg::BCNT_W-1:0]     bcx;
  logic [s3tc_pkg::BCNT_W-1:0]     bcy;
  logic [s3tc_pkg::BCNT_W-1:0]     col_ext;
  logic [s3tc_pkg::BCNT_W-1:0]     row_ext;
  logic                            in_image;
  logic [s3tc_pkg::SIZE_W-1:0]     rem_w;
  logic [s3tc_pkg::SIZE_W-1:0]     rem_h;
  logic [1:0]                      cx_last;
  logic [1:0]                      cy_last;

  logic [15:0]                     c0;
  logic [15:0]                     c1;
  logic                            four_color;
  s3tc_pkg::chan4_t                red_p;
  s3tc_pkg::chan4_t                grn_p;
  s3tc_pkg::chan4_t                blu_p;

  logic                            step;
  logic                            em_done;
  logic                            xfer;
  logic [3:0]                      pix;
  logic [1:0]                      ci;
  logic [3:0]                      nib;
  logic [5:0]                      a5_pos;
  logic [2:0]                      a5_idx;
  logic [7:0]                      alpha;
  logic [s3tc_pkg::COORD_W-1:0]    px;
  logic [s3tc_pkg::COORD_W-1:0]    py;
  logic                            pix_last;

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

  assign step     = !out_valid_r || out_tready;
  assign pix_last = (cx_r == em_cx_last_r) && (cy_r == em_cy_last_r);
  assign em_done  = em_valid_r && step && pix_last;
  assign xfer     = inq_valid_r && (!em_valid_r || em_done);
  assign in_tready = !inq_valid_r || xfer;

  // Image geometry for the block waiting in the input register.
  always_comb begin
    if (width_r == '0) begin
      w_clamp = s3tc_pkg::SIZE_W'(1);
    end else if (width_r > s3tc_pkg::SIZE_W'(s3tc_pkg::MAX_IMAGE_SIZE)) begin
      w_clamp = s3tc_pkg::SIZE_W'(s3tc_pkg::MAX_IMAGE_SIZE);
    end else begin
      w_clamp = width_r;
    end
    if (height_r == '0) begin
      h_clamp = s3tc_pkg::SIZE_W'(1);
    end else if (height_r > s3tc_pkg::SIZE_W'(s3tc_pkg::MAX_IMAGE_SIZE)) begin
      h_clamp = s3tc_pkg::SIZE_W'(s3tc_pkg::MAX_IMAGE_SIZE);
    end else begin
      h_clamp = height_r;
    end
    bcx      = s3tc_pkg::BCNT_W'(({1'b0, w_clamp} + 14'd3) >> 2);
    bcy      = s3tc_pkg::BCNT_W'(({1'b0, h_clamp} + 14'd3) >> 2);
    col_ext  = s3tc_pkg::BCNT_W'(col_r);
    row_ext  = s3tc_pkg::BCNT_W'(row_r);
    in_image = (col_ext < bcx) && (row_ext < bcy);
    rem_w    = w_clamp - s3tc_pkg::SIZE_W'({col_r, 2'b00});
    rem_h    = h_clamp - s3tc_pkg::SIZE_W'({row_r, 2'b00});
    cx_last  = (rem_w >= s3tc_pkg::SIZE_W'(4)) ? 2'd3 : 2'(rem_w[1:0] - 2'd1);
    cy_last  = (rem_h >= s3tc_pkg::SIZE_W'(4)) ? 2'd3 : 2'(rem_h[1:0] - 2'd1);
  end

  // Color palette of the block waiting in the input register.
  always_comb begin
    c0 = inq_cw_r[15:0];
    c1 = inq_cw_r[31:16];
    four_color = (fmt_r != s3tc_pkg::FMT_DXT1) || (c0 > c1);
    red_p[0] = s3tc_pkg::exp5(c0[15:11]);
    grn_p[0] = s3tc_pkg::exp6(c0[10:5]);
    blu_p[0] = s3tc_pkg::exp5(c0[4:0]);
    red_p[1] = s3tc_pkg::exp5(c1[15:11]);
    grn_p[1] = s3tc_pkg::exp6(c1[10:5]);
    blu_p[1] = s3tc_pkg::exp5(c1[4:0]);
    if (four_color) begin
      red_p[2] = s3tc_pkg::div3({1'b0, red_p[0], 1'b0} + 10'(red_p[1]));
      red_p[3] = s3tc_pkg::div3(10'(red_p[0]) + {1'b0, red_p[1], 1'b0});
      grn_p[2] = s3tc_pkg::div3({1'b0, grn_p[0], 1'b0} + 10'(grn_p[1]));
      grn_p[3] = s3tc_pkg::div3(10'(grn_p[0]) + {1'b0, grn_p[1], 1'b0});
      blu_p[2] = s3tc_pkg::div3({1'b0, blu_p[0], 1'b0} + 10'(blu_p[1]));
      blu_p[3] = s3tc_pkg::div3(10'(blu_p[0]) + {1'b0, blu_p[1], 1'b0});
    end else begin
      red_p[2] = 8'((9'(red_p[0]) + 9'(red_p[1])) >> 1);
      grn_p[2] = 8'((9'(grn_p[0]) + 9'(grn_p[1])) >> 1);
      blu_p[2] = 8'((9'(blu_p[0]) + 9'(blu_p[1])) >> 1);
      red_p[3] = 8'd0;
      grn_p[3] = 8'd0;
      blu_p[3] = 8'd0;
    end
  end

  // Pixel selection inside the block being emitted.
  always_comb begin
    pix    = {cy_r, cx_r};
    ci     = em_idx_r[{pix, 1'b0} +: 2];
    nib    = em_aw_r[{pix, 2'b00} +: 4];
    a5_pos = 6'd16 + 6'({pix, 1'b0}) + 6'(pix);
    a5_idx = em_aw_r[a5_pos +: 3];
    unique case (em_fmt_r)
      s3tc_pkg::FMT_DXT1: alpha = (em_trans_r && (ci == 2'd3)) ? 8'd0 : 8'd255;
      s3tc_pkg::FMT_DXT3: alpha = {nib, nib};
      default:            alpha = em_atab_r[a5_idx];
    endcase
    px = {em_col_r, cx_r};
    py = {em_row_r, cy_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r    <= s3tc_pkg::FMT_DXT1;
      width_r  <= s3tc_pkg::SIZE_W'(4);
      height_r <= s3tc_pkg::SIZE_W'(4);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        s3tc_pkg::CFG_FORMAT: fmt_r    <= cfg_data[1:0];
        s3tc_pkg::CFG_WIDTH:  width_r  <= cfg_data;
        s3tc_pkg::CFG_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_valid_r <= 1'b0;
    end else if (in_tready) begin
      inq_valid_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      inq_aw_r <= in_tdata[63:0];
      inq_cw_r <= in_tdata[127:64];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      em_valid_r <= 1'b0;
      cx_r       <= 2'd0;
      cy_r       <= 2'd0;
    end else begin
      if (xfer) begin
        em_valid_r <= in_image;
        cx_r       <= 2'd0;
        cy_r       <= 2'd0;
        if (col_ext + s3tc_pkg::BCNT_W'(1) >= bcx) begin
          col_r <= '0;
          row_r <= (row_ext + s3tc_pkg::BCNT_W'(1) >= bcy) ? '0 : row_r + 1'b1;
        end else begin
          col_r <= col_r + 1'b1;
        end
      end else if (em_done) begin
        em_valid_r <= 1'b0;
      end else if (em_valid_r && step) begin
        if (cx_r == em_cx_last_r) begin
          cx_r <= 2'd0;
          cy_r <= cy_r + 2'd1;
        end else begin
          cx_r <= cx_r + 2'd1;
        end
      end
    end
    if (xfer) begin
      em_fmt_r      <= fmt_r;
      em_trans_r    <= !four_color;
      em_red_r      <= red_p;
      em_grn_r      <= grn_p;
      em_blu_r      <= blu_p;
      em_atab_r     <= s3tc_pkg::alpha_table(inq_aw_r[7:0], inq_aw_r[15:8]);
      em_idx_r      <= inq_cw_r[63:32];
      em_aw_r       <= inq_aw_r;
      em_col_r      <= col_r;
      em_row_r      <= row_r;
      em_cx_last_r  <= cx_last;
      em_cy_last_r  <= cy_last;
      em_last_blk_r <= (col_ext == bcx - s3tc_pkg::BCNT_W'(1)) &&
                       (row_ext == bcy - s3tc_pkg::BCNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= em_valid_r;
    end
    if (step && em_valid_r) begin
      out_data_r <= {alpha, em_blu_r[ci], em_grn_r[ci], em_red_r[ci], py, px};
      out_last_r <= pix_last;
      out_user_r <= pix_last && em_last_blk_r;
    end
  end

endmodule
